[rtl/block_mapped_flash_translation_defines.svh]
// Assertion macros shared by the flash translation RTL.
`ifndef BLOCK_MAPPED_FLASH_TRANSLATION_DEFINES_SVH
`define BLOCK_MAPPED_FLASH_TRANSLATION_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BMFT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BMFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/bmft_pkg.sv]
// Package with the widths, codes and sequencer states of the flash translation block.
`timescale 1ns / 1ps
package bmft_pkg;

  localparam int unsigned SN_W     = 9;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned PAGE_W   = 10;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned PAGES_PER_BLK_DEF = 16;
  localparam int unsigned DATA_BLOCKS_DEF   = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ    = 2'd0,
    CMD_PROGRAM = 2'd1,
    CMD_COPY    = 2'd2,
    CMD_ERASE   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_UNMAPPED = 2'd1,
    ST_NO_FREE  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_LOOKUP,
    S_DECIDE,
    S_PW_WAIT,
    S_PW_CHECK,
    S_COPY,
    S_ERASE
  } state_e;

endpackage

[rtl/block_mapped_flash_translation.sv]
// Block-mapped flash translation: sector requests in, page commands out.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  in      | sink      | in_valid_i / in_stall_o  | action_i, sector_number_i
//  out     | source    | out_valid_o / out_stall_i| command_o, target_page_o, source_page_o,
//          |           |                         | status_o, last_o
//
// Items: a read, a first write, a write to a free page and an overwrite all start with two
//   split steps; an overwrite then sends one command a cycle while out_stall_i is low.
// Reset: a clearing pass sweeps the map and the written-page
//   memory; no item is taken until it ends.
// Stalls: out_stall_i holds the sequencer wherever a command is due; the
//   output register keeps the last command while the next item is accepted.
`timescale 1ns / 1ps
`include "block_mapped_flash_translation_defines.svh"
module block_mapped_flash_translation #(
  parameter int unsigned PAGES_PER_BLK = bmft_pkg::PAGES_PER_BLK_DEF,
  parameter int unsigned DATA_BLOCKS   = bmft_pkg::DATA_BLOCKS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [bmft_pkg::SN_W-1:0]     sector_number_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bmft_pkg::CMD_W-1:0]    command_o,
  output logic [bmft_pkg::PAGE_W-1:0]   target_page_o,
  output logic [bmft_pkg::PAGE_W-1:0]   source_page_o,
  output logic [bmft_pkg::STATUS_W-1:0] status_o,
  output logic                          last_o
);
  import bmft_pkg::*;

  localparam int unsigned OFFW        = $clog2(PAGES_PER_BLK);
  localparam int unsigned PHYS_BLOCKS = DATA_BLOCKS + 1;
  localparam int unsigned PBW         = $clog2(PHYS_BLOCKS);
  localparam int unsigned LBN_AW      = $clog2(DATA_BLOCKS);
  localparam int unsigned LW          = (PBW > SN_W) ? PBW : SN_W;
  localparam int unsigned PGW         = ((PBW + OFFW) > PAGE_W) ? (PBW + OFFW) : PAGE_W;
  localparam int unsigned DIVCW       = 1;
  localparam int unsigned RECIP_SH    = SN_W + OFFW;
  localparam int unsigned PRODW       = SN_W + RECIP_SH;

  // Rounded-up reciprocal of the page count: exact quotient for every sector number.
  localparam logic [RECIP_SH-1:0] RECIP =
    RECIP_SH'(((1 << RECIP_SH) + PAGES_PER_BLK - 1) / PAGES_PER_BLK);
  localparam logic [PBW-1:0]     DATA_BLK_CNT = PBW'(DATA_BLOCKS);
  localparam logic [OFFW-1:0]    LAST_OFF     = OFFW'(PAGES_PER_BLK - 1);
  localparam logic [DIVCW-1:0]   DIV_LAST     = DIVCW'(1);
  localparam logic [LW-1:0]      LBN_LIMIT    = LW'(DATA_BLOCKS);

  // Physical page of a block and an offset, cut to the port width.
  function automatic logic [PAGE_W-1:0] phys_page(logic [PBW-1:0] blk, logic [OFFW-1:0] pg);
    logic [PGW-1:0] full;
    full = PGW'(blk) * PGW'(PAGES_PER_BLK) + PGW'(pg);
    return full[PAGE_W-1:0];
  endfunction

  // Sequencer and working registers.
  state_e                   state_q, state_d;
  logic                     action_q;
  logic [SN_W-1:0]          quo_q;       // sector number, then the logical block
  logic [OFFW-1:0]          rem_q;       // page offset once the split ends
  logic [DIVCW-1:0]         div_cnt_q;
  logic [PBW-1:0]           pbn_q;
  logic [PBW-1:0]           spare_q;
  logic [PBW-1:0]           alloc_q;     // next never-used data block
  logic [PBW-1:0]           clr_q;
  logic [OFFW-1:0]          page_cnt_q;
  logic [PAGES_PER_BLK-1:0] old_pw_q;

  // Output register.
  logic                     out_valid_q;
  cmd_e                     cmd_q, cmd_d;
  logic [PAGE_W-1:0]        tgt_q, tgt_d;
  logic [PAGE_W-1:0]        src_q, src_d;
  status_e                  status_q, status_d;
  logic                     last_q, last_d;

  // Memories: map entry is {mapped, physical block}; one written-page bitmap per block.
  logic [PBW:0]             map_mem [0:DATA_BLOCKS-1];
  logic [PAGES_PER_BLK-1:0] pw_mem  [0:PHYS_BLOCKS-1];
  logic [PBW:0]             map_rd_q;
  logic [PAGES_PER_BLK-1:0] pw_rd_q;

  logic                     map_we, pw_we;
  logic [LBN_AW-1:0]        map_wa;
  logic [PBW:0]             map_wd;
  logic [PBW-1:0]           pw_wa;
  logic [PAGES_PER_BLK-1:0] pw_wd;

  logic                     emit, out_free, alloc_take, in_accept, erase_go, copy_out;
  logic [PRODW-1:0]         quo_prod;
  logic [OFFW-1:0]          blk_lo;
  logic [LW-1:0]            lbn_ext;
  logic [LBN_AW-1:0]        lbn_addr;
  logic                     in_range, map_hit, has_free, single_res, page_free;
  logic [PBW-1:0]           map_pbn;
  logic [PAGES_PER_BLK-1:0] off_bit;

  // Split the sector number: the block by reciprocal multiply, then the offset
  // from the low bits less those of block times page count.
  assign quo_prod = PRODW'(quo_q) * PRODW'(RECIP);
  assign blk_lo   = OFFW'(quo_q) * OFFW'(PAGES_PER_BLK);

  assign lbn_ext  = LW'(quo_q);
  assign lbn_addr = lbn_ext[LBN_AW-1:0];
  assign in_range = (lbn_ext < LBN_LIMIT);
  assign map_hit  = map_rd_q[PBW];
  assign map_pbn  = map_rd_q[PBW-1:0];
  // Blocks are handed out in order and never returned, and the spare is never handed out, so the
  // first free block is simply the count of blocks handed out so far.
  assign has_free = (alloc_q < DATA_BLK_CNT);
  assign off_bit  = {{(PAGES_PER_BLK - 1){1'b0}}, 1'b1} << rem_q;
  assign page_free = ((pw_rd_q & off_bit) == '0);
  assign single_res = !in_range || !action_q || !map_hit;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_accept = in_valid_i && !in_stall_o;
  assign erase_go  = (state_q == S_ERASE) && out_free;
  assign copy_out  = out_valid_o && (command_o == CMD_COPY);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == DATA_BLK_CNT) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_DIV;
      end
      S_DIV: begin
        if (div_cnt_q == DIV_LAST) state_d = S_LOOKUP;
      end
      S_LOOKUP: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (!single_res) begin
          state_d = S_PW_WAIT;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_PW_WAIT: begin
        state_d = S_PW_CHECK;
      end
      S_PW_CHECK: begin
        if (!page_free) begin
          state_d = S_COPY;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_COPY: begin
        if (out_free && (page_cnt_q == LAST_OFF)) state_d = S_ERASE;
      end
      S_ERASE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Commands, memory writes and handshake.
  always_comb begin
    emit       = 1'b0;
    alloc_take = 1'b0;
    cmd_d      = CMD_READ;
    tgt_d      = '0;
    src_d      = '0;
    status_d   = ST_OK;
    last_d     = 1'b1;
    map_we     = 1'b0;
    map_wa     = lbn_addr;
    map_wd     = '0;
    pw_we      = 1'b0;
    pw_wa      = pbn_q;
    pw_wd      = '0;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_CLEAR: begin
        map_we = (clr_q < DATA_BLK_CNT);
        map_wa = clr_q[LBN_AW-1:0];
        pw_we  = 1'b1;
        pw_wa  = clr_q;
      end
      S_DECIDE: begin
        emit = out_free && single_res;
        if (!in_range) begin
          status_d = action_q ? ST_NO_FREE : ST_UNMAPPED;
        end else if (!action_q) begin
          if (!map_hit) begin
            status_d = ST_UNMAPPED;
          end else begin
            tgt_d = phys_page(map_pbn, rem_q);
          end
        end else if (!map_hit) begin
          if (has_free) begin
            // A never-used block has an empty bitmap: write the single page bit.
            alloc_take = out_free;
            cmd_d      = CMD_PROGRAM;
            tgt_d      = phys_page(alloc_q, rem_q);
            map_we     = out_free;
            map_wd     = {1'b1, alloc_q};
            pw_we      = out_free;
            pw_wa      = alloc_q;
            pw_wd      = off_bit;
          end else begin
            status_d = ST_NO_FREE;
          end
        end
      end
      S_PW_CHECK: begin
        if (page_free) begin
          emit  = out_free;
          cmd_d = CMD_PROGRAM;
          tgt_d = phys_page(pbn_q, rem_q);
          pw_we = out_free;
          pw_wd = pw_rd_q | off_bit;
        end
      end
      S_COPY: begin
        emit   = out_free;
        last_d = 1'b0;
        tgt_d  = phys_page(spare_q, page_cnt_q);
        if (page_cnt_q == rem_q) begin
          cmd_d = CMD_PROGRAM;
        end else begin
          cmd_d = CMD_COPY;
          src_d = phys_page(pbn_q, page_cnt_q);
        end
        // Merged bitmap goes to the spare with the first command.
        pw_we = out_free && (page_cnt_q == '0);
        pw_wa = spare_q;
        pw_wd = old_pw_q | off_bit;
      end
      S_ERASE: begin
        emit   = out_free;
        cmd_d  = CMD_ERASE;
        tgt_d  = phys_page(pbn_q, '0);
        pw_we  = out_free;
        map_we = out_free;
        map_wd = {1'b1, spare_q};
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      spare_q     <= DATA_BLK_CNT;
      alloc_q     <= '0;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
      page_cnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (alloc_take) alloc_q <= alloc_q + 1'b1;
      // Swap the erased block in as the new spare.
      if (erase_go) spare_q <= pbn_q;
      if (in_accept) begin
        div_cnt_q <= '0;
      end else if (state_q == S_DIV) begin
        div_cnt_q <= div_cnt_q + 1'b1;
      end
      if (state_q == S_PW_CHECK) begin
        page_cnt_q <= '0;
      end else if (state_q == S_COPY && out_free) begin
        page_cnt_q <= page_cnt_q + 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      action_q <= action_i;
      quo_q    <= sector_number_i;
      rem_q    <= sector_number_i[OFFW-1:0];
    end else if (state_q == S_DIV) begin
      if (div_cnt_q == '0) begin
        quo_q <= quo_prod[PRODW-1 -: SN_W];
      end else begin
        rem_q <= rem_q - blk_lo;
      end
    end
    if (state_q == S_DECIDE) pbn_q <= map_pbn;
    if (state_q == S_PW_CHECK) old_pw_q <= pw_rd_q;
    if (emit) begin
      cmd_q    <= cmd_d;
      tgt_q    <= tgt_d;
      src_q    <= src_d;
      status_q <= status_d;
      last_q   <= last_d;
    end
  end

  // Memories, one write and one registered read each.
  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (pw_we) pw_mem[pw_wa] <= pw_wd;
    map_rd_q <= map_mem[lbn_addr];
    pw_rd_q  <= pw_mem[pbn_q];
  end

  assign out_valid_o   = out_valid_q;
  assign command_o     = cmd_q;
  assign target_page_o = tgt_q;
  assign source_page_o = src_q;
  assign status_o      = status_q;
  assign last_o        = last_q;

  `BMFT_ASSERT_NEXT(a_accept_starts_div, in_accept, state_q == S_DIV, "no split after accept")
  `BMFT_ASSERT_IMPL(a_copy_not_last, copy_out, !last_o && (status_o == ST_OK), "bad copy item")
  `BMFT_ASSERT_NEXT(a_erase_swaps_spare, erase_go, spare_q == $past(pbn_q), "spare not swapped")
  `BMFT_ASSERT_IMPL(a_alloc_bounded, 1'b1, alloc_q <= DATA_BLK_CNT, "allocation past data blocks")

endmodule
